/* sv/bidi_pkg.sv */
`timescale 1ns / 1ps

package bidi_pkg;

  // coarsened bidirectional classes
  typedef enum logic [3:0] {
    CLS_L   = 4'd0,
    CLS_R   = 4'd1,
    CLS_EN  = 4'd2,
    CLS_AN  = 4'd3,
    CLS_ES  = 4'd4,
    CLS_CS  = 4'd5,
    CLS_ET  = 4'd6,
    CLS_NSM = 4'd7,
    CLS_B   = 4'd8,
    CLS_ON  = 4'd9
  } bidi_cls_t;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned CLS_W = 4;

  typedef logic [CP_W-1:0] codepoint_t;

endpackage

/* sv/bidi_class_classifier.sv */
`timescale 1ns / 1ps
// pipeline: input reg, then result reg, between input transaction and result transaction
// throughput: one codepoint per cycle; input stalls only when both stages are
//   full and the result side stalls
// reset: synchronous active-low rst_n clears both stage valid bits, no payload reset

module bidi_class_classifier (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bidi_pkg::CP_W-1:0]        in_codepoint,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bidi_pkg::CLS_W-1:0]       out_bidi_class
);

  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  bidi_pkg::codepoint_t s1_cp_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  bidi_pkg::bidi_cls_t  out_cls_r;
  bidi_pkg::bidi_cls_t  lookup_cls;
  logic                 out_free;
  logic                 s1_free;
  logic                 in_take;

  // stage enables
  assign out_free = !out_valid_r || !out_stall;
  assign s1_free  = !s1_valid_r || out_free;
  assign in_take  = in_valid && s1_free;
  assign in_stall = !s1_free;

  always_comb begin
    s1_valid_nxt  = in_take || (s1_valid_r && !out_free);
    out_valid_nxt = (s1_valid_r && out_free) || (out_valid_r && out_stall);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cp_r <= in_codepoint;
    end
  end

  bidi_lookup u_lookup (
    .cp  (s1_cp_r),
    .cls (lookup_cls)
  );

  // result register
  always_ff @(posedge clk) begin
    if (s1_valid_r && out_free) begin
      out_cls_r <= lookup_cls;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bidi_class = out_cls_r;

  // a new result only appears from a full input stage
  a_rise_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a staged transaction");

  // class code stays in range
  a_cls_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cls_r <= bidi_pkg::CLS_ON))
    else $error("class code out of range");

  // ascii digits give EN
  a_digit_en: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_free && s1_cp_r >= 21'h30 && s1_cp_r <= 21'h39)
    |=> (out_cls_r == bidi_pkg::CLS_EN))
    else $error("ascii digit not classed EN");

  // a held result is not overwritten while the input stage is full
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && s1_valid_r) |=> (s1_valid_r && out_valid_r))
    else $error("staged transaction lost under stall");

endmodule

/* sv/bidi_lookup.sv */
`timescale 1ns / 1ps

module bidi_lookup (
  input  bidi_pkg::codepoint_t cp,
  output bidi_pkg::bidi_cls_t  cls
);

  logic is_mark;

  // combining mark ranges, hebrew punctuation left out
  always_comb begin
    is_mark = (cp inside {
      [21'h000300:21'h00036F], [21'h000591:21'h0005C7],
      [21'h000610:21'h00061A], [21'h00064B:21'h00065F], 21'h000670,
      [21'h0006D6:21'h0006DC], [21'h0006DF:21'h0006E4],
      [21'h0006E7:21'h0006E8], [21'h0006EA:21'h0006ED],
      [21'h000730:21'h00074A], [21'h0007A6:21'h0007B0],
      [21'h0007EB:21'h0007F3], 21'h0007FD, [21'h000898:21'h00089F],
      [21'h0008CA:21'h0008E1], [21'h0008E3:21'h0008FF],
      [21'h001AB0:21'h001AFF], [21'h001DC0:21'h001DFF],
      [21'h0020D0:21'h0020FF], [21'h00FE00:21'h00FE0F],
      [21'h00FE20:21'h00FE2F]})
      && !(cp inside {21'h0005BE, 21'h0005C0, 21'h0005C3, 21'h0005C6});
  end

  // precedence chain
  always_comb begin
    if (cp < 21'h000080) begin
      if (cp inside {[21'h30:21'h39]}) begin
        cls = bidi_pkg::CLS_EN;
      end else if (cp inside {[21'h41:21'h5A], [21'h61:21'h7A]}) begin
        cls = bidi_pkg::CLS_L;
      end else if (cp inside {21'h0A, 21'h0D}) begin
        cls = bidi_pkg::CLS_B;
      end else if (cp inside {[21'h23:21'h25]}) begin
        cls = bidi_pkg::CLS_ET;
      end else if (cp inside {21'h2B, 21'h2D}) begin
        cls = bidi_pkg::CLS_ES;
      end else if (cp inside {21'h2C, 21'h2E, 21'h2F, 21'h3A}) begin
        cls = bidi_pkg::CLS_CS;
      end else begin
        cls = bidi_pkg::CLS_ON;
      end
    end else if (is_mark) begin
      cls = bidi_pkg::CLS_NSM;
    end else if (cp inside {[21'h000590:21'h0005FF]}) begin
      cls = bidi_pkg::CLS_R;
    end else if (cp inside {[21'h000600:21'h0006FF]}) begin
      // arabic block with number, comma and percent exceptions
      if (cp inside {[21'h000600:21'h000605], [21'h000660:21'h000669],
                     21'h00066B, 21'h00066C, 21'h0006DD}) begin
        cls = bidi_pkg::CLS_AN;
      end else if (cp inside {[21'h0006F0:21'h0006F9]}) begin
        cls = bidi_pkg::CLS_EN;
      end else if (cp == 21'h00060C) begin
        cls = bidi_pkg::CLS_CS;
      end else if (cp inside {21'h000609, 21'h00060A, 21'h00066A}) begin
        cls = bidi_pkg::CLS_ET;
      end else begin
        cls = bidi_pkg::CLS_R;
      end
    end else if (cp inside {[21'h000700:21'h0008FF]}) begin
      if (cp inside {21'h000890, 21'h000891, 21'h0008E2}) begin
        cls = bidi_pkg::CLS_AN;
      end else begin
        cls = bidi_pkg::CLS_R;
      end
    end else if (cp inside {[21'h00FB1D:21'h00FDFF], [21'h00FE70:21'h00FEFC]}) begin
      cls = bidi_pkg::CLS_R;
    end else if (cp == 21'h0000A0) begin
      cls = bidi_pkg::CLS_CS;
    end else if (cp inside {21'h0000B0, 21'h0000B1, 21'h0020AC}) begin
      cls = bidi_pkg::CLS_ET;
    end else if (cp == 21'h002212) begin
      cls = bidi_pkg::CLS_ES;
    end else if (cp == 21'h00200E) begin
      cls = bidi_pkg::CLS_L;
    end else if (cp == 21'h00200F) begin
      cls = bidi_pkg::CLS_R;
    end else if (cp inside {[21'h0000A1:21'h0000BF], [21'h002000:21'h002BFF],
                            [21'h01F000:21'h01FAFF]}) begin
      cls = bidi_pkg::CLS_ON;
    end else begin
      cls = bidi_pkg::CLS_L;
    end
  end

endmodule
